>>> sv/aise_pkg.sv
// Shared types and constants for the array insert/delete/search engine.
`default_nettype none
package aise_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 7;
  localparam int OP_W         = 2;
  localparam int ST_W         = 3;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_SEARCH   = 2'd2,
    OP_TRAVERSE = 2'd3
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

endpackage
`default_nettype wire

>>> sv/aise_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module aise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/array_insert_delete_search_engine.sv
// Top level: packed array with insert, delete, linear search and traverse.
//
// Holds up to CAPACITY signed 32-bit values in a single RAM (one write and
// one registered read port) plus an element count. One request is worked at
// a time; s_axis_tready is high only while the sequencer is idle, though a
// finished result may still wait in the output register. Insert shifts the
// entries from the position upward up one place and writes the value, delete
// shifts the entries above the position down one place, search reads from
// index 0 up to the first match, and traverse gives one result per cycle while
// the output register is free. The RAM ports move one entry per cycle. The
// store needs no clearing after reset.
`default_nettype none
module array_insert_delete_search_engine #(
  parameter int CAPACITY = aise_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  wire logic [aise_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [aise_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [31:0] element, [38:32] index, [41:39] status, [48:42] count_after, [55:49] zero
  output logic      [aise_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                                m_axis_tlast
);
  import aise_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_SRCH,
    S_TRAV,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [ADDR_W-1:0]   wa_q, wa_d;
  logic                pend_q, pend_d;
  logic [DATA_W-1:0]   val_q, val_d;
  status_e             res_st_q, res_st_d;
  logic [IDX_W-1:0]    ridx_q, ridx_d;

  logic                o_vld_q, o_vld_d;
  logic [DATA_W-1:0]   o_elem_q, o_elem_d;
  logic [IDX_W-1:0]    o_idx_q, o_idx_d;
  status_e             o_st_q, o_st_d;
  logic [IDX_W-1:0]    o_cnt_q, o_cnt_d;
  logic                o_last_q, o_last_d;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  logic                s_accept, out_free;
  logic [IDX_W-1:0]    in_pos, count_ext;
  logic [DATA_W-1:0]   in_val;
  logic [CNT_W-1:0]    ptr_dec;
  logic [CNT_W:0]      ptr_inc;

  aise_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !o_vld_q || m_axis_tready;
  assign in_pos        = s_axis_tdata[IDX_W-1:0];
  assign in_val        = s_axis_tdata[IDX_W +: DATA_W];
  assign count_ext     = IDX_W'(count_q);
  assign ptr_dec       = ptr_q - 1'b1;
  assign ptr_inc       = {1'b0, ptr_q} + 1'b1;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    wa_d     = wa_q;
    pend_d   = pend_q;
    val_d    = val_q;
    res_st_d = res_st_q;
    ridx_d   = ridx_q;
    o_vld_d  = o_vld_q && !m_axis_tready;
    o_elem_d = o_elem_q;
    o_idx_d  = o_idx_q;
    o_st_d   = o_st_q;
    o_cnt_d  = o_cnt_q;
    o_last_d = o_last_q;
    ram_we    = 1'b0;
    ram_waddr = wa_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[ADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          val_d  = in_val;
          pos_d  = in_pos[CNT_W-1:0];
          pend_d = 1'b0;
          ridx_d = '0;
          ptr_d  = '0;
          case (opcode_e'(s_axis_tuser))
            OP_INSERT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_st_d = ST_FULL;
                state_d  = S_RESP;
              end else if (in_pos > count_ext) begin
                res_st_d = ST_BADPOS;
                state_d  = S_RESP;
              end else begin
                ptr_d   = count_q;
                state_d = S_INS;
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_RESP;
              end else if (in_pos >= count_ext) begin
                res_st_d = ST_BADPOS;
                state_d  = S_RESP;
              end else begin
                ptr_d   = in_pos[CNT_W-1:0];
                state_d = S_DEL;
              end
            end
            OP_SEARCH: begin
              state_d = S_SRCH;
            end
            default: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = S_TRAV;
              end
            end
          endcase
        end
      end

      S_INS: begin
        if (ptr_q > pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_dec[ADDR_W-1:0];
          ram_we    = pend_q;
          pend_d    = 1'b1;
          wa_d      = ptr_q[ADDR_W-1:0];
          ptr_d     = ptr_dec;
        end else if (pend_q) begin
          ram_we = 1'b1;
          pend_d = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[ADDR_W-1:0];
          ram_wdata = val_q;
          count_d   = count_q + 1'b1;
          res_st_d  = ST_OK;
          state_d   = S_RESP;
        end
      end

      S_DEL: begin
        if (ptr_inc < {1'b0, count_q}) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc[ADDR_W-1:0];
          ram_we    = pend_q;
          pend_d    = 1'b1;
          wa_d      = ptr_q[ADDR_W-1:0];
          ptr_d     = ptr_inc[CNT_W-1:0];
        end else if (pend_q) begin
          ram_we = 1'b1;
          pend_d = 1'b0;
        end else begin
          count_d  = count_q - 1'b1;
          res_st_d = ST_OK;
          state_d  = S_RESP;
        end
      end

      S_SRCH: begin
        if (pend_q && (ram_rdata == val_q)) begin
          res_st_d = ST_OK;
          ridx_d   = IDX_W'(wa_q);
          state_d  = S_RESP;
        end else if (ptr_q < count_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          wa_d   = ptr_q[ADDR_W-1:0];
          ptr_d  = ptr_inc[CNT_W-1:0];
        end else begin
          res_st_d = ST_NOTFOUND;
          ridx_d   = '0;
          state_d  = S_RESP;
        end
      end

      S_TRAV: begin
        if (out_free) begin
          o_vld_d  = 1'b1;
          o_elem_d = ram_rdata;
          o_idx_d  = IDX_W'(ptr_q);
          o_st_d   = ST_OK;
          o_cnt_d  = count_ext;
          o_last_d = (ptr_inc == {1'b0, count_q});
          if (ptr_inc == {1'b0, count_q}) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_inc[ADDR_W-1:0];
            ptr_d     = ptr_inc[CNT_W-1:0];
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          o_vld_d  = 1'b1;
          o_elem_d = '0;
          o_idx_d  = ridx_q;
          o_st_d   = res_st_q;
          o_cnt_d  = count_ext;
          o_last_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      pos_q    <= '0;
      wa_q     <= '0;
      pend_q   <= 1'b0;
      val_q    <= '0;
      res_st_q <= ST_OK;
      ridx_q   <= '0;
      o_vld_q  <= 1'b0;
      o_elem_q <= '0;
      o_idx_q  <= '0;
      o_st_q   <= ST_OK;
      o_cnt_q  <= '0;
      o_last_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      pos_q    <= pos_d;
      wa_q     <= wa_d;
      pend_q   <= pend_d;
      val_q    <= val_d;
      res_st_q <= res_st_d;
      ridx_q   <= ridx_d;
      o_vld_q  <= o_vld_d;
      o_elem_q <= o_elem_d;
      o_idx_q  <= o_idx_d;
      o_st_q   <= o_st_d;
      o_cnt_q  <= o_cnt_d;
      o_last_q <= o_last_d;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - 2 * IDX_W - ST_W){1'b0}},
                          o_cnt_q, o_st_q, o_idx_q, o_elem_q};

endmodule
`default_nettype wire

>>> sv/aise_checker.sv
// Port-level checker for the array engine, with its bind.
`default_nettype none
module aise_checker #(
  parameter int CAPACITY = aise_pkg::CAPACITY_DEF
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [aise_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic [aise_pkg::OP_W-1:0]      s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [aise_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tlast
);
  import aise_pkg::*;

  logic [DATA_W-1:0] elem;
  logic [ST_W-1:0]   st;
  logic [IDX_W-1:0]  cnt;

  assign elem = m_axis_tdata[DATA_W-1:0];
  assign st   = m_axis_tdata[DATA_W+IDX_W +: ST_W];
  assign cnt  = m_axis_tdata[DATA_W+IDX_W+ST_W +: IDX_W];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine ready right after a transaction");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st != ST_OK) |-> m_axis_tlast)
    else $error("error result not marked last");

  a_error_no_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st != ST_OK) |-> (elem == '0))
    else $error("error result carries an element");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt <= IDX_W'(CAPACITY)))
    else $error("count beyond capacity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind array_insert_delete_search_engine aise_checker #(.CAPACITY(CAPACITY)) u_aise_checker (.*);
`default_nettype wire

>>> dv/testbench.sv
// Testbench for the array insert/delete/search engine: directed table, random phases, scoreboard.
module testbench;
  import aise_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN       = CAPACITY + 16;
  localparam int IDLE_LIMIT  = 4 * (HOLD_CYCLES + CAPACITY + 16);
  localparam int N_DIRECTED  = 22;

  typedef struct packed {
    logic [DATA_W-1:0] element;
    logic [IDX_W-1:0]  index;
    status_e           status;
    logic [IDX_W-1:0]  count_after;
    logic              last;
  } result_t;

  typedef struct packed {
    opcode_e           op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              fixed;
    status_e           st;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  cnt;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  logic [DATA_W-1:0] shadow_store [CAPACITY];
  int                shadow_count = 0;
  result_t           step_results [$];
  result_t           awaited_results [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                send_calm = 0;

  // fixed rows expect a single result: element 0, last 1
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_TRAVERSE, 7'd0,   32'h0000_0000, 1'b1, ST_EMPTY,    7'd0, 7'd0},
    '{OP_DELETE,   7'd0,   32'h0000_0000, 1'b1, ST_EMPTY,    7'd0, 7'd0},
    '{OP_SEARCH,   7'd0,   32'h0000_0000, 1'b1, ST_NOTFOUND, 7'd0, 7'd0},
    '{OP_INSERT,   7'd1,   32'h0000_0001, 1'b1, ST_BADPOS,   7'd0, 7'd0},
    '{OP_INSERT,   7'd127, 32'hFFFF_FFFF, 1'b1, ST_BADPOS,   7'd0, 7'd0},
    '{OP_INSERT,   7'd0,   32'h8000_0000, 1'b1, ST_OK,       7'd0, 7'd1},
    '{OP_INSERT,   7'd1,   32'h7FFF_FFFF, 1'b1, ST_OK,       7'd0, 7'd2},
    '{OP_INSERT,   7'd0,   32'h0000_0000, 1'b1, ST_OK,       7'd0, 7'd3},
    '{OP_INSERT,   7'd2,   32'hFFFF_FFFF, 1'b1, ST_OK,       7'd0, 7'd4},
    '{OP_INSERT,   7'd1,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 7'd0},
    '{OP_SEARCH,   7'd0,   32'h7FFF_FFFF, 1'b0, ST_OK,       7'd0, 7'd0},
    '{OP_SEARCH,   7'd0,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 7'd0},
    '{OP_SEARCH,   7'd0,   32'h0000_1234, 1'b1, ST_NOTFOUND, 7'd0, 7'd5},
    '{OP_TRAVERSE, 7'd0,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 7'd0},
    '{OP_DELETE,   7'd5,   32'h0000_0000, 1'b1, ST_BADPOS,   7'd0, 7'd5},
    '{OP_DELETE,   7'd127, 32'h0000_0000, 1'b1, ST_BADPOS,   7'd0, 7'd5},
    '{OP_DELETE,   7'd4,   32'h0000_0000, 1'b1, ST_OK,       7'd0, 7'd4},
    '{OP_DELETE,   7'd0,   32'h0000_0000, 1'b1, ST_OK,       7'd0, 7'd3},
    '{OP_SEARCH,   7'd0,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 7'd0},
    '{OP_TRAVERSE, 7'd0,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 7'd0},
    '{OP_INSERT,   7'd3,   32'h5555_AAAA, 1'b1, ST_OK,       7'd0, 7'd4},
    '{OP_SEARCH,   7'd0,   32'h5555_AAAA, 1'b0, ST_OK,       7'd0, 7'd0}
  };

  array_insert_delete_search_engine #(.CAPACITY(CAPACITY)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial forever #1 clk_i = ~clk_i;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // random wait, with occasional calm stretches of back-to-back transactions
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // updates the shadow array and leaves this request's results in step_results
  task automatic apply_request(opcode_e op, logic [IDX_W-1:0] pos, logic [DATA_W-1:0] val);
    result_t r;
    bit      hit;
    step_results.delete();
    r   = '{element: '0, index: '0, status: ST_OK, count_after: '0, last: 1'b1};
    hit = 1'b0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else if (pos > shadow_count) r.status = ST_BADPOS;
        else begin
          for (int i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i-1];
          shadow_store[pos] = val;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (pos >= shadow_count) r.status = ST_BADPOS;
        else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_store[i] = shadow_store[i+1];
          shadow_count--;
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_store[i] == val) begin
            hit      = 1'b1;
            r.status = ST_OK;
            r.index  = IDX_W'(i);
          end
        end
      end
      default: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          for (int i = 0; i < shadow_count; i++) begin
            step_results.push_back('{element: shadow_store[i], index: IDX_W'(i), status: ST_OK,
                                     count_after: IDX_W'(shadow_count),
                                     last: (i + 1 == shadow_count)});
          end
        end
      end
    endcase
    if (!(op == OP_TRAVERSE && shadow_count != 0)) begin
      r.count_after = IDX_W'(shadow_count);
      step_results.push_back(r);
    end
  endtask

  task automatic offer(opcode_e op, logic [IDX_W-1:0] pos, logic [DATA_W-1:0] val,
                       bit fixed, result_t typed_result);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, pos};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(op, pos, val);
    if (fixed) awaited_results.push_back(typed_result);
    else foreach (step_results[k]) awaited_results.push_back(step_results[k]);
  endtask

  initial begin : stimulus
    opcode_e           op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    result_t           typed;
    int                pick;
    int                items;
    bit                filling;
    bit                cycled;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (directed_rows[k]) begin
      typed = '{element: '0, index: directed_rows[k].idx, status: directed_rows[k].st,
                count_after: directed_rows[k].cnt, last: 1'b1};
      offer(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
            directed_rows[k].fixed, typed);
    end

    // let the engine drain completely before the random phases
    s_axis_tvalid <= 1'b0;
    wait (awaited_results.size() == 0);
    @(posedge clk_i);

    // insert-heavy fill, delete-heavy drain until full and empty again; at most 130 requests
    items   = 0;
    filling = 1'b1;
    cycled  = 1'b0;
    while ((items < 78 || !cycled) && items < 130) begin
      pick = $urandom_range(0, 99);
      if (filling)
        op = opcode_e'(pick < 75 ? OP_INSERT : pick < 85 ? OP_SEARCH :
                       pick < 92 ? OP_DELETE : OP_TRAVERSE);
      else
        op = opcode_e'(pick < 70 ? OP_DELETE : pick < 80 ? OP_SEARCH :
                       pick < 87 ? OP_INSERT : OP_TRAVERSE);
      if ($urandom_range(0, 6) == 0) pos = IDX_W'($urandom_range(0, 127));
      else if (op == OP_INSERT) pos = IDX_W'($urandom_range(0, shadow_count));
      else if (shadow_count == 0) pos = '0;
      else pos = IDX_W'($urandom_range(0, shadow_count - 1));
      if (op == OP_SEARCH && shadow_count > 0 && $urandom_range(0, 2) != 0)
        val = shadow_store[$urandom_range(0, shadow_count - 1)];
      else if ($urandom_range(0, 3) == 0) val = $urandom_range(0, 3);
      else val = $urandom;
      if (filling && op == OP_INSERT && shadow_count == CAPACITY) filling = 1'b0;
      else if (!filling && op == OP_DELETE && shadow_count == 0) begin
        filling = 1'b1;
        cycled  = 1'b1;
      end
      offer(op, pos, val, 1'b0, '0);
      items++;
    end

    s_axis_tvalid <= 1'b0;
    wait (awaited_results.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      mismatches++;
    end
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : receiver
    int gap;
    int taken;
    int calm;
    taken = 0;
    calm  = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // one long hold-off so the engine backs up and stalls its input
      gap = (taken == 60) ? HOLD_CYCLES : draw_gap(calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{element: m_axis_tdata[31:0], index: m_axis_tdata[38:32],
              status: status_e'(m_axis_tdata[41:39]), count_after: m_axis_tdata[48:42],
              last: m_axis_tlast};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: elem %h idx %0d st %0d cnt %0d last %0b",
                   got.element, got.index, got.status, got.count_after, got.last);
      end else begin
        want = awaited_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %0d %0d %0d %0b, got %h %0d %0d %0d %0b",
                     want.element, want.index, want.status, want.count_after, want.last,
                     got.element, got.index, got.status, got.count_after, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
